FILE: src/tls_pkg.sv
`default_nettype none

package tls_pkg;

   // request codes
   localparam logic [1:0] REQ_TICK   = 2'd0;
   localparam logic [1:0] REQ_ON     = 2'd1;
   localparam logic [1:0] REQ_OFF    = 2'd2;
   localparam logic [1:0] REQ_STATUS = 2'd3;

   // field widths
   localparam int REQ_TYPE_W  = 2;
   localparam int IDX_W       = 3;
   localparam int SECS_W      = 16;
   localparam int COUNT_W     = 26;
   localparam int LINE_OUT_W  = 4;

   // parameter defaults
   localparam int LINES_DEFAULT = 4;
   localparam int TPS_DEFAULT   = 1000;

   typedef logic [COUNT_W-1:0] count_type;

endpackage

`default_nettype wire

FILE: src/timed_line_switch_core.sv
// Timed line switch: drives up to LINES output lines, each switched on for a
// number of seconds. Requests are a one millisecond tick, switch on, switch off
// and status query; every request beat gives exactly one response beat carrying
// the remaining milliseconds (status query on an active line that has not run
// out), a bad index flag and the state of lines 0 to 3 after the request. A line
// that has run out stays on until a status query or an off request switches it off.
// One request is taken every clock cycle while the response side does not stall;
// a request goes through the input register, then one pass over all lines into
// the response register, and back pressure on the response side stalls both.
`default_nettype none

module timed_line_switch_core
   import tls_pkg::*;
#(
   parameter int LINES            = LINES_DEFAULT,
   parameter int TICKS_PER_SECOND = TPS_DEFAULT
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire logic [REQ_TYPE_W-1:0]  req_type,
   input  wire logic [IDX_W-1:0]       req_line_index,
   input  wire logic [SECS_W-1:0]      req_duration_secs,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output logic [COUNT_W-1:0]          rsp_remaining_ms,
   output logic                        rsp_bad_index,
   output logic [LINE_OUT_W-1:0]       rsp_line_outputs
);

   localparam logic [IDX_W:0] LINES_LIM = (IDX_W+1)'(LINES);

   // input register
   logic                   s1_valid_ff, s1_valid_in;
   logic [REQ_TYPE_W-1:0]  s1_type_ff;
   logic [IDX_W-1:0]       s1_idx_ff;
   count_type              s1_load_ff;
   count_type              load_ms;

   // line state
   count_type              count_ff [LINES];
   count_type              count_in [LINES];
   logic [LINES-1:0]       active_ff, active_in;
   logic [LINES-1:0]       overdue_ff, overdue_in;

   // response register
   logic                   rsp_valid_ff, rsp_valid_in;
   count_type              rem_ff, rem_in;
   logic                   bad_ff, bad_in;
   logic [LINE_OUT_W-1:0]  lines_ff, lines_in;

   logic                   advance;
   logic                   fire;
   logic                   bad;

   // pipeline moves when the response register is free or being emptied
   assign advance   = !rsp_valid_ff || rsp_ready;
   assign fire      = s1_valid_ff && advance;
   assign req_ready = !s1_valid_ff || advance;

   // on-time in milliseconds, worked out before the input register
   assign load_ms = COUNT_W'(COUNT_W'(req_duration_secs) * COUNT_W'(TICKS_PER_SECOND));

   assign s1_valid_in = (req_valid && req_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (req_valid && req_ready) begin
         s1_type_ff <= req_type;
         s1_idx_ff  <= req_line_index;
         s1_load_ff <= load_ms;
      end
   end

   // bad index applies to all but the tick
   assign bad = (s1_type_ff != REQ_TICK) && ({1'b0, s1_idx_ff} >= LINES_LIM);

   // single pass over all lines
   always_comb begin
      active_in  = active_ff;
      overdue_in = overdue_ff;
      rem_in     = '0;
      for (int i = 0; i < LINES; i++) begin
         count_in[i] = count_ff[i];
      end
      for (int i = 0; i < LINES; i++) begin
         if (s1_type_ff == REQ_TICK) begin
            if (active_ff[i] && !overdue_ff[i]) begin
               if (count_ff[i] == '0) begin
                  overdue_in[i] = 1'b1;
               end else begin
                  count_in[i] = count_ff[i] - COUNT_W'(1);
               end
            end
         end else if (!bad && (s1_idx_ff == IDX_W'(i))) begin
            case (s1_type_ff)
               REQ_ON: begin
                  if (!active_ff[i]) begin
                     count_in[i]   = s1_load_ff;
                     active_in[i]  = 1'b1;
                     overdue_in[i] = 1'b0;
                  end
               end
               REQ_OFF: begin
                  if (active_ff[i]) begin
                     count_in[i]   = '0;
                     active_in[i]  = 1'b0;
                     overdue_in[i] = 1'b0;
                  end
               end
               default: begin
                  if (active_ff[i]) begin
                     if (overdue_ff[i]) begin
                        count_in[i]   = '0;
                        active_in[i]  = 1'b0;
                        overdue_in[i] = 1'b0;
                     end else begin
                        rem_in = count_ff[i];
                     end
                  end
               end
            endcase
         end
      end
   end

   // visible lines, taken after the update
   genvar g;
   generate
      for (g = 0; g < LINE_OUT_W; g++) begin : g_out
         if (g < LINES) begin : g_used
            assign lines_in[g] = active_in[g];
         end else begin : g_unused
            assign lines_in[g] = 1'b0;
         end
      end
   endgenerate

   assign bad_in       = bad;
   assign rsp_valid_in = advance ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= '0;
         overdue_ff   <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < LINES; i++) begin
            count_ff[i] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            active_ff  <= active_in;
            overdue_ff <= overdue_in;
            for (int i = 0; i < LINES; i++) begin
               count_ff[i] <= count_in[i];
            end
         end
      end
      if (fire) begin
         rem_ff   <= rem_in;
         bad_ff   <= bad_in;
         lines_ff <= lines_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_remaining_ms = rem_ff;
   assign rsp_bad_index    = bad_ff;
   assign rsp_line_outputs = lines_ff;

   // a line can only be overdue while it is on
   a_overdue_active: assert property (@(posedge clock) disable iff (reset)
      (overdue_ff & ~active_ff) == '0)
      else $error("overdue line not active");

   // a bad index never reports time left
   a_bad_no_rem: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bad_index |-> rsp_remaining_ms == '0)
      else $error("bad index beat with remaining time");

   // a tick never flags a bad index
   a_tick_not_bad: assert property (@(posedge clock) disable iff (reset)
      fire && (s1_type_ff == REQ_TICK) |=> !rsp_bad_index)
      else $error("tick flagged bad index");

   // lines that are off hold no count
   generate
      for (g = 0; g < LINES; g++) begin : g_chk
         a_off_zero: assert property (@(posedge clock) disable iff (reset)
            !active_ff[g] |-> count_ff[g] == '0)
            else $error("inactive line holds a count");
      end
   endgenerate

endmodule

`default_nettype wire
